// ----- sv/pafl_pkg.sv -----
// Shared constants, types and control structures of the page allocator free list.
package pafl_pkg;

   localparam int FREE_DEPTH = 256;
   localparam int PAGE_W = 31;
   localparam int POS_W = 8;
   localparam int FREE_CNT_W = 9;
   localparam int CNT_W = $clog2(FREE_DEPTH + 1);
   localparam int IDX_W = $clog2(FREE_DEPTH);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [PAGE_W-1:0] PAGE_MAX = {PAGE_W{1'b1}};
   localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(FREE_DEPTH);

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_BAD_POS   = 2'd2,
      ST_EXHAUSTED = 2'd3
   } status_type;

   typedef struct packed {
      logic             shift_en;
      logic [IDX_W-1:0] shift_from;
      logic             write_en;
      logic [IDX_W-1:0] write_at;
   } cell_ctl_type;

endpackage

// ----- sv/pafl_if.sv -----
// Request and response channel interfaces of the page allocator free list.
interface pafl_req_if;
   import pafl_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic [PAGE_W-1:0] page_number;
   logic [POS_W-1:0]  position;

   modport source (output valid, output opcode, output page_number, output position,
                   input ready);
   modport sink (input valid, input opcode, input page_number, input position,
                 output ready);
endinterface

interface pafl_rsp_if;
   import pafl_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [PAGE_W-1:0]     alloc_page;
   logic [1:0]            status;
   logic [FREE_CNT_W-1:0] free_count;

   modport source (output valid, output alloc_page, output status, output free_count,
                   input ready);
   modport sink (input valid, input alloc_page, input status, input free_count,
                 output ready);
endinterface

// ----- sv/pafl_cell.sv -----
// One entry of the free list, taking its neighbour's page on a shift or a new page on a write.
module pafl_cell (
   input  logic                         clock,
   input  pafl_pkg::cell_ctl_type       ctl,
   input  logic [pafl_pkg::IDX_W-1:0]   idx,
   input  logic [pafl_pkg::PAGE_W-1:0]  next_page,
   input  logic [pafl_pkg::PAGE_W-1:0]  write_page,
   output logic [pafl_pkg::PAGE_W-1:0]  page
);
   import pafl_pkg::*;

   logic [PAGE_W-1:0] page_ff;
   logic [PAGE_W-1:0] page_in;

   always_comb begin
      page_in = page_ff;
      if (ctl.shift_en && (idx >= ctl.shift_from)) begin
         page_in = next_page;
      end else if (ctl.write_en && (idx == ctl.write_at)) begin
         page_in = write_page;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

   assign page = page_ff;

endmodule

// ----- sv/pafl_chain.sv -----
// Row of free list cells, each but the last fed by its upper neighbour, with the oldest page at the head.
module pafl_chain (
   input  logic                         clock,
   input  pafl_pkg::cell_ctl_type       ctl,
   input  logic [pafl_pkg::PAGE_W-1:0]  write_page,
   output logic [pafl_pkg::PAGE_W-1:0]  head_page
);
   import pafl_pkg::*;

   logic [PAGE_W-1:0] page_w [FREE_DEPTH];

   for (genvar k = 0; k < FREE_DEPTH; k++) begin : g_cell
      logic [PAGE_W-1:0] next_w;

      if (k == FREE_DEPTH - 1) begin : g_last
         assign next_w = page_w[k];
      end else begin : g_mid
         assign next_w = page_w[k+1];
      end

      pafl_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .idx        (IDX_W'(k)),
         .next_page  (next_w),
         .write_page (write_page),
         .page       (page_w[k])
      );
   end

   assign head_page = page_w[0];

endmodule

// ----- sv/page_allocator_free_list.sv -----
// Page allocator with an ordered free list held in a shifting row of cells and a page counter.
// The response beat is registered and presented in the cycle after its request beat is accepted.
// Throughput: one request beat per cycle; the cell row closes any gap in that same cycle.
// A request is held off only while a response beat waits and the sink is not ready.
// Synchronous reset empties the list, clears the page counter and drops any pending response.
module page_allocator_free_list (
   input  logic                        clock,
   input  logic                        reset,
   pafl_req_if.sink                    req_ch,
   pafl_rsp_if.source                  rsp_ch,
   input  logic                        csr_write_en,
   input  logic [pafl_pkg::PAGE_W-1:0] csr_write_data
);
   import pafl_pkg::*;

   logic              accept;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [PAGE_W-1:0] last_ff;
   logic [PAGE_W-1:0] last_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [PAGE_W-1:0] rsp_page_ff;
   logic [PAGE_W-1:0] rsp_page_in;
   status_type        rsp_status_ff;
   status_type        rsp_status_in;
   logic [FREE_CNT_W-1:0] rsp_count_ff;
   logic [PAGE_W-1:0] head_page;
   cell_ctl_type      ctl;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      count_in = count_ff;
      last_in = last_ff;
      rsp_page_in = '0;
      rsp_status_in = ST_OK;
      ctl = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
         case (op_type'(req_ch.opcode))
            OP_ALLOC: begin
               if (count_ff != '0) begin
                  rsp_page_in = head_page;
                  ctl.shift_en = 1'b1;
                  ctl.shift_from = '0;
                  count_in = count_ff - CNT_W'(1);
               end else if (last_ff == PAGE_MAX) begin
                  rsp_status_in = ST_EXHAUSTED;
               end else begin
                  last_in = last_ff + PAGE_W'(1);
                  rsp_page_in = last_ff + PAGE_W'(1);
               end
            end
            OP_FREE: begin
               if (count_ff >= COUNT_FULL) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  ctl.write_en = 1'b1;
                  ctl.write_at = IDX_W'(count_ff);
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_REMOVE: begin
               if (CMP_W'(req_ch.position) >= CMP_W'(count_ff)) begin
                  rsp_status_in = ST_BAD_POS;
               end else begin
                  ctl.shift_en = 1'b1;
                  ctl.shift_from = IDX_W'(req_ch.position);
                  count_in = count_ff - CNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
      if (csr_write_en) begin
         last_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         last_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         last_ff <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_page_ff <= rsp_page_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff <= FREE_CNT_W'(count_in);
      end
   end

   pafl_chain u_chain (
      .clock      (clock),
      .ctl        (ctl),
      .write_page (req_ch.page_number),
      .head_page  (head_page)
   );

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.alloc_page = rsp_page_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.free_count = rsp_count_ff;

`ifndef ASSERT_OFF
   a_free_grows: assert property (@(posedge clock) disable iff (reset)
      accept && (req_ch.opcode == OP_FREE) && (count_ff < COUNT_FULL)
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("free into a list with room did not grow the count");

   a_fresh_page: assert property (@(posedge clock) disable iff (reset)
      accept && !csr_write_en && (req_ch.opcode == OP_ALLOC) && (count_ff == '0)
      && (last_ff != PAGE_MAX)
      |=> (last_ff == $past(last_ff) + PAGE_W'(1)) && (rsp_page_ff == last_ff))
      else $error("allocate from an empty list did not hand out the next counter page");

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_count_ff == FREE_CNT_W'(count_ff))
      else $error("response beat count differs from the list count");
`endif

endmodule

// ----- bench/tb_top.sv -----
// Self-checking page allocator free list bench, directed and random traffic scored per beat.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pafl_pkg::*;

   typedef struct packed {
      logic [PAGE_W-1:0]     page;
      status_type            status;
      logic [FREE_CNT_W-1:0] count;
   } alloc_beat_type;

   class page_ledger;
      logic [PAGE_W-1:0] cells [FREE_DEPTH];
      int unsigned       held;
      logic [PAGE_W-1:0] last_page;
      alloc_beat_type    awaited [$];
      int                mismatches;
      int                beats_checked;
      int                requests_noted;
      int                peak_held;
      int                full_drops;
      int                exhausted_allocs;
      int                bad_removes;

      function new();
         held = 0;
         last_page = '0;
         mismatches = 0;
         beats_checked = 0;
         requests_noted = 0;
         peak_held = 0;
         full_drops = 0;
         exhausted_allocs = 0;
         bad_removes = 0;
      endfunction

      function void load_counter(logic [PAGE_W-1:0] value);
         last_page = value;
      endfunction

      function int unsigned depth();
         return held;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void close_gap(int unsigned idx);
         for (int unsigned k = idx; k + 1 < held; k++) begin
            cells[k] = cells[k + 1];
         end
         held--;
      endfunction

      function void note_request(op_type op, logic [PAGE_W-1:0] page,
                                 logic [POS_W-1:0] pos);
         alloc_beat_type beat;
         beat.page = '0;
         beat.status = ST_OK;
         requests_noted++;
         case (op)
            OP_ALLOC: begin
               if (held > 0) begin
                  beat.page = cells[0];
                  close_gap(0);
               end else if (last_page == PAGE_MAX) begin
                  beat.status = ST_EXHAUSTED;
                  exhausted_allocs++;
               end else begin
                  last_page = last_page + 1'b1;
                  beat.page = last_page;
               end
            end
            OP_FREE: begin
               if (held >= FREE_DEPTH) begin
                  beat.status = ST_FULL;
                  full_drops++;
               end else begin
                  cells[held] = page;
                  held++;
               end
            end
            OP_REMOVE: begin
               if (pos >= held) begin
                  beat.status = ST_BAD_POS;
                  bad_removes++;
               end else begin
                  close_gap(pos);
               end
            end
            default: begin
            end
         endcase
         if (held > peak_held) peak_held = int'(held);
         beat.count = FREE_CNT_W'(held);
         awaited.push_back(beat);
      endfunction

      function void check_response(logic [PAGE_W-1:0] page, logic [1:0] status,
                                   logic [FREE_CNT_W-1:0] count);
         alloc_beat_type want;
         beats_checked++;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb_top: unexpected response beat: page %h status %0d count %0d",
                        page, status, count);
            return;
         end
         want = awaited.pop_front();
         if (page !== want.page || status !== want.status || count !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb_top: beat %0d expected page %h %s count %0d, got %h %0d count %0d",
                        beats_checked, want.page, want.status.name(), want.count,
                        page, status, count);
         end
      endfunction
   endclass

   localparam int QUIET_LIMIT = 2000;

   logic              clock;
   logic              reset = 1'b1;
   logic              csr_write_en;
   logic [PAGE_W-1:0] csr_write_data;
   int                quiet_cycles;
   int                send_left;
   bit                send_quiet;

   pafl_req_if req_if ();
   pafl_rsp_if rsp_if ();

   page_ledger ledger = new();

   page_allocator_free_list uut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_if),
      .rsp_ch         (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int draw_wait(inout int left, inout bit quiet);
      if (left == 0) begin
         left = $urandom_range(5, 60);
         quiet = ($urandom_range(0, 3) == 0);
      end
      left--;
      return quiet ? 0 : $urandom_range(0, 17);
   endfunction

   task automatic send_request(op_type op, logic [PAGE_W-1:0] page, logic [POS_W-1:0] pos);
      int gap;
      gap = draw_wait(send_left, send_quiet);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.opcode <= op;
      req_if.page_number <= page;
      req_if.position <= pos;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      ledger.note_request(op, page, pos);
   endtask

   task automatic write_start(logic [PAGE_W-1:0] value);
      req_if.valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      ledger.load_counter(value);
   endtask

   task automatic run_phase(int items, int w_alloc, int w_free, int w_remove);
      op_type            op;
      int                roll;
      int                pick;
      logic [POS_W-1:0]  pos;
      for (int i = 0; i < items; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < w_alloc) op = OP_ALLOC;
         else if (roll < w_alloc + w_free) op = OP_FREE;
         else if (roll < w_alloc + w_free + w_remove) op = OP_REMOVE;
         else op = OP_NOP;
         pos = POS_W'($urandom_range(0, 255));
         if (op == OP_REMOVE) begin
            pick = $urandom_range(0, 9);
            if (pick < 7 && ledger.depth() > 0)
               pos = POS_W'($urandom_range(0, ledger.depth() - 1));
            else if (pick == 7 && ledger.depth() <= 255)
               pos = POS_W'(ledger.depth());
         end
         send_request(op, PAGE_W'($urandom), pos);
      end
   endtask

   initial begin
      int stall;
      int left;
      bit quiet;
      left = 0;
      quiet = 1'b0;
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = draw_wait(left, quiet);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         ledger.check_response(rsp_if.alloc_page, rsp_if.status, rsp_if.free_count);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid === 1'b1 && req_if.ready === 1'b1)
          || (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: no beat for %0d cycles", quiet_cycles);
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   initial begin
      send_left = 0;
      send_quiet = 1'b0;
      req_if.valid <= 1'b0;
      req_if.opcode <= OP_NOP;
      req_if.page_number <= '0;
      req_if.position <= '0;
      csr_write_en <= 1'b0;
      csr_write_data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_request(OP_NOP, PAGE_MAX, 8'hFF);
      send_request(OP_ALLOC, '0, '0);
      send_request(OP_REMOVE, '0, 8'd0);
      send_request(OP_FREE, '0, '0);
      send_request(OP_FREE, PAGE_MAX, 8'hFF);
      send_request(OP_FREE, 31'h2AAA_AAAA, 8'hAA);
      send_request(OP_FREE, 31'h5555_5555, 8'h55);
      send_request(OP_REMOVE, '0, POS_W'(ledger.depth()));
      send_request(OP_REMOVE, '0, 8'hFF);
      send_request(OP_REMOVE, '0, 8'd1);
      send_request(OP_ALLOC, PAGE_MAX, 8'hFF);
      send_request(OP_REMOVE, '0, POS_W'(ledger.depth() - 1));
      send_request(OP_ALLOC, '0, '0);
      send_request(OP_ALLOC, '0, '0);
      write_start(PAGE_MAX - 1'b1);
      send_request(OP_ALLOC, '0, '0);
      send_request(OP_ALLOC, '0, '0);
      send_request(OP_FREE, 31'h0123_4567, '0);
      send_request(OP_ALLOC, '0, '0);
      send_request(OP_ALLOC, '0, '0);
      send_request(OP_NOP, '0, '0);

      write_start('0);
      run_phase(350, 30, 35, 25);
      write_start(PAGE_MAX - 31'd40);
      run_phase(250, 60, 20, 15);
      write_start(PAGE_MAX);
      run_phase(700, 10, 75, 10);
      write_start(PAGE_W'($urandom));
      run_phase(550, 45, 15, 35);

      req_if.valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("tb_top: %0d requests, %0d response beats checked, %0d mismatches",
               ledger.requests_noted, ledger.beats_checked, ledger.mismatches);
      $display("tb_top: list peaked at %0d, %0d full drops, %0d bad removes, %0d exhausted allocs",
               ledger.peak_held, ledger.full_drops, ledger.bad_removes,
               ledger.exhausted_allocs);
      if (ledger.mismatches == 0 && ledger.pending() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
sv/pafl_pkg.sv
sv/pafl_if.sv
sv/pafl_cell.sv
sv/pafl_chain.sv
sv/page_allocator_free_list.sv
bench/tb_top.sv
